/* rtl/foft_pkg.sv */
// ----------------------------------------------------------------------------
// foft_pkg: shared definitions for the frequency ordered table
// sizes, operation and status codes, cell control and state structs
// ----------------------------------------------------------------------------
package foft_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int USED_W     = $clog2(ENTRIES + 1);

    // payload widths of the channels
    localparam int OP_W     = 2;
    localparam int KEY_W    = 8;
    localparam int RANK_W   = 4;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int OCOUNT_W = 16;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_LOCATE = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_RANK   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FIND = 3'b010,
        S_MOVE = 3'b100
    } t_state;

    typedef struct packed {
        logic load;   // take the broadcast key and count
        logic shift;  // take the neighbor's key and count
    } t_cell_ctl;

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [COUNT_BITS-1:0] count;
        logic                  match;  // stored key equals broadcast key
        logic                  le;     // stored count <= broadcast count
    } t_cell_stat;

endpackage

/* rtl/foft_if.sv */
// ----------------------------------------------------------------------------
// foft_in_if / foft_out_if: valid-ready channels of the table
// request beats in, result beats out
// ----------------------------------------------------------------------------
interface foft_in_if;
    logic                          valid;
    logic                          ready;
    logic [foft_pkg::OP_W-1:0]     operation;
    logic [foft_pkg::KEY_W-1:0]    key;
    logic [foft_pkg::RANK_W-1:0]   rank;

    modport source (output valid, output operation, output key, output rank, input ready);
    modport sink   (input valid, input operation, input key, input rank, output ready);
endinterface

interface foft_out_if;
    logic                          valid;
    logic                          ready;
    logic [foft_pkg::STATUS_W-1:0] status;
    logic [foft_pkg::POS_W-1:0]    position;
    logic [foft_pkg::KEY_W-1:0]    entry_key;
    logic [foft_pkg::OCOUNT_W-1:0] entry_count;

    modport source (output valid, output status, output position, output entry_key,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input position, input entry_key,
                    input entry_count, output ready);
endinterface

/* rtl/foft_cell.sv */
// ----------------------------------------------------------------------------
// foft_cell: one rank of the table
// holds a key and its count, compares against the broadcast, shifts down
// ----------------------------------------------------------------------------
module foft_cell (
    input  logic                                i_clk,
    input  foft_pkg::t_cell_ctl                 i_ctl,
    input  logic [foft_pkg::KEY_W-1:0]          i_prev_key,
    input  logic [foft_pkg::COUNT_BITS-1:0]     i_prev_count,
    input  logic [foft_pkg::KEY_W-1:0]          i_bcast_key,
    input  logic [foft_pkg::COUNT_BITS-1:0]     i_bcast_count,
    output foft_pkg::t_cell_stat                o_stat
);

    logic [foft_pkg::KEY_W-1:0]      r_key;
    logic [foft_pkg::COUNT_BITS-1:0] r_count;
    logic [foft_pkg::KEY_W-1:0]      n_key;
    logic [foft_pkg::COUNT_BITS-1:0] n_count;

    always_comb begin
        n_key   = r_key;
        n_count = r_count;
        if (i_ctl.load) begin
            n_key   = i_bcast_key;
            n_count = i_bcast_count;
        end else if (i_ctl.shift) begin
            n_key   = i_prev_key;
            n_count = i_prev_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_count <= n_count;
    end

    assign o_stat.key   = r_key;
    assign o_stat.count = r_count;
    assign o_stat.match = (r_key == i_bcast_key);
    assign o_stat.le    = (r_count <= i_bcast_count);

endmodule

/* rtl/frequency_ordered_table_top.sv */
// ----------------------------------------------------------------------------
// frequency_ordered_table_top: self-organizing table ordered by access count
// a chain of rank cells with a small sequencer for append, locate and read
// ----------------------------------------------------------------------------
// usage
//   i_in carries one request beat: operation, key, rank. o_out returns exactly
//   one result beat per request: status, position, entry_key, entry_count.
//   append and read are accepted in idle, then answered from the find state,
//   where the cells compare and the read is selected; locate of a present key
//   adds a move state: the insertion-point search against the incremented
//   count followed by the shift of the cell chain.
//   one request is in flight at a time: a new one is accepted only once
//   the sequencer has walked the cell chain back to idle.
//   a finished result sits in the output register; i_in.ready is high in
//   idle when that register is empty or is being drained in the same cycle,
//   so a stalled receiver holds off new requests but loses nothing.
//   reset (synchronous, active low) empties the table and the output
//   register; cell contents are left as they are and never read until an
//   append writes them.
// ----------------------------------------------------------------------------
module frequency_ordered_table_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    foft_in_if.sink           i_in,
    foft_out_if.source        o_out
);

    localparam int N = foft_pkg::ENTRIES;

    // sequencer and request registers
    foft_pkg::t_state                r_state, n_state;
    logic [foft_pkg::OP_W-1:0]       r_op;
    logic [foft_pkg::KEY_W-1:0]      r_key;
    logic [foft_pkg::RANK_W-1:0]     r_rank;
    logic [foft_pkg::USED_W-1:0]     r_used, n_used;

    // locate hit, carried from the compare cycle to the move cycle
    logic [N-1:0]                    r_hit_oh, n_hit_oh;
    logic [foft_pkg::IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic [foft_pkg::COUNT_BITS-1:0] r_cnt, n_cnt;

    // output register
    logic                            r_out_valid, n_out_valid;
    logic [foft_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [foft_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [foft_pkg::KEY_W-1:0]      r_okey, n_okey;
    logic [foft_pkg::OCOUNT_W-1:0]   r_ocnt, n_ocnt;

    // cell chain
    foft_pkg::t_cell_ctl             cell_ctl  [N];
    foft_pkg::t_cell_stat            cell_stat [N];
    logic [foft_pkg::COUNT_BITS-1:0] bcast_count;

    logic                            in_fire;
    logic                            out_fire;
    logic [N-1:0]                    occ;
    logic [N-1:0]                    hit_vec;
    logic [N-1:0]                    hit_first;
    logic [foft_pkg::IDX_W-1:0]      hit_idx;
    logic [foft_pkg::COUNT_BITS-1:0] hit_cnt;
    logic [N-1:0]                    cand;
    logic [N-1:0]                    ins_oh;
    logic [foft_pkg::IDX_W-1:0]      ins_idx;
    logic [foft_pkg::KEY_W-1:0]      rd_key;
    logic [foft_pkg::COUNT_BITS-1:0] rd_cnt;
    logic                            table_full;
    logic                            rank_ok;
    logic [N-1:0]                    load_vec;
    logic [N-1:0]                    shift_vec;

    assign out_fire   = o_out.valid & o_out.ready;
    assign i_in.ready = (r_state == foft_pkg::S_IDLE) & (~r_out_valid | o_out.ready);
    assign in_fire    = i_in.valid & i_in.ready;

    assign table_full  = (r_used == foft_pkg::USED_W'(N));
    assign rank_ok     = (int'(r_rank) < int'(r_used));
    // zero for append, the incremented count when moving a located entry
    assign bcast_count = (r_state == foft_pkg::S_MOVE) ? r_cnt : '0;

    // per-rank decode: occupancy, matches, read selection, insertion point
    always_comb begin
        rd_key  = '0;
        rd_cnt  = '0;
        hit_cnt = '0;
        hit_idx = '0;
        ins_idx = '0;
        for (int i = 0; i < N; i++) begin
            occ[i]     = (foft_pkg::USED_W'(i) < r_used);
            hit_vec[i] = cell_stat[i].match & occ[i];
            if (int'(r_rank) == i) begin
                rd_key = cell_stat[i].key;
                rd_cnt = cell_stat[i].count;
            end
        end
        // highest-ranked match: lowest set bit
        hit_first = hit_vec & (~hit_vec + 1'b1);
        for (int i = 0; i < N; i++) begin
            if (hit_first[i]) begin
                hit_idx = foft_pkg::IDX_W'(i);
                hit_cnt = cell_stat[i].count;
            end
            // entries ahead of the hit whose count is now <= the new count
            cand[i] = (cell_stat[i].le & (foft_pkg::IDX_W'(i) < r_hit_idx)) | r_hit_oh[i];
        end
        ins_oh = cand & (~cand + 1'b1);
        for (int i = 0; i < N; i++) begin
            if (ins_oh[i]) begin
                ins_idx = foft_pkg::IDX_W'(i);
            end
        end
    end

    // cell controls
    always_comb begin
        for (int i = 0; i < N; i++) begin
            load_vec[i]  = 1'b0;
            shift_vec[i] = 1'b0;
            if (r_state == foft_pkg::S_FIND && r_op == foft_pkg::OP_APPEND && !table_full) begin
                load_vec[i] = (int'(r_used) == i);
            end else if (r_state == foft_pkg::S_MOVE) begin
                load_vec[i]  = ins_oh[i];
                shift_vec[i] = (foft_pkg::IDX_W'(i) > ins_idx) &
                               (foft_pkg::IDX_W'(i) <= r_hit_idx);
            end
            cell_ctl[i].load  = load_vec[i];
            cell_ctl[i].shift = shift_vec[i];
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_hit_oh    = r_hit_oh;
        n_hit_idx   = r_hit_idx;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~out_fire;
        n_status    = r_status;
        n_pos       = r_pos;
        n_okey      = r_okey;
        n_ocnt      = r_ocnt;
        case (r_state)
            foft_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = foft_pkg::S_FIND;
                end
            end
            foft_pkg::S_FIND: begin
                n_state = foft_pkg::S_IDLE;
                n_okey  = r_key;
                n_ocnt  = '0;
                n_pos   = '0;
                if (r_op == foft_pkg::OP_APPEND) begin
                    n_out_valid = 1'b1;
                    if (table_full) begin
                        n_status = foft_pkg::ST_FULL;
                    end else begin
                        n_status = foft_pkg::ST_OK;
                        n_pos    = foft_pkg::POS_W'(r_used);
                        n_used   = r_used + 1'b1;
                    end
                end else if (r_op == foft_pkg::OP_LOCATE) begin
                    if (|hit_vec) begin
                        // saturating count bump, move happens next cycle
                        n_state   = foft_pkg::S_MOVE;
                        n_hit_oh  = hit_first;
                        n_hit_idx = hit_idx;
                        n_cnt     = (&hit_cnt) ? hit_cnt : hit_cnt + 1'b1;
                    end else begin
                        n_out_valid = 1'b1;
                        n_status    = foft_pkg::ST_NOT_FOUND;
                    end
                end else begin
                    // upper operation bit selects read
                    n_out_valid = 1'b1;
                    n_pos       = foft_pkg::POS_W'(r_rank);
                    if (rank_ok) begin
                        n_status = foft_pkg::ST_OK;
                        n_okey   = rd_key;
                        n_ocnt   = foft_pkg::OCOUNT_W'(rd_cnt);
                    end else begin
                        n_status = foft_pkg::ST_NO_RANK;
                        n_okey   = '0;
                    end
                end
            end
            foft_pkg::S_MOVE: begin
                n_state     = foft_pkg::S_IDLE;
                n_out_valid = 1'b1;
                n_status    = foft_pkg::ST_OK;
                n_pos       = foft_pkg::POS_W'(ins_idx);
                n_okey      = r_key;
                n_ocnt      = foft_pkg::OCOUNT_W'(r_cnt);
            end
            default: begin
                n_state = foft_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= foft_pkg::S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= i_in.operation;
            r_key  <= i_in.key;
            r_rank <= i_in.rank;
        end
        r_hit_oh  <= n_hit_oh;
        r_hit_idx <= n_hit_idx;
        r_cnt     <= n_cnt;
        r_status  <= n_status;
        r_pos     <= n_pos;
        r_okey    <= n_okey;
        r_ocnt    <= n_ocnt;
    end

    // rank cells, each fed by the rank above it
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [foft_pkg::KEY_W-1:0]      prev_key;
        logic [foft_pkg::COUNT_BITS-1:0] prev_count;
        if (g == 0) begin : g_head
            assign prev_key   = '0;
            assign prev_count = '0;
        end else begin : g_link
            assign prev_key   = cell_stat[g-1].key;
            assign prev_count = cell_stat[g-1].count;
        end
        foft_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl[g]),
            .i_prev_key    (prev_key),
            .i_prev_count  (prev_count),
            .i_bcast_key   (r_key),
            .i_bcast_count (bcast_count),
            .o_stat        (cell_stat[g])
        );
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.position    = r_pos;
    assign o_out.entry_key   = r_okey;
    assign o_out.entry_count = r_ocnt;

`ifndef SYNTHESIS
    // result slot is empty whenever a locate is being moved
    a_move_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == foft_pkg::S_MOVE) |-> !r_out_valid)
        else $error("output register busy during move");

    // a move always produces its result in the following cycle
    a_move_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == foft_pkg::S_MOVE) |=> (r_out_valid && r_status == foft_pkg::ST_OK))
        else $error("move did not deliver a result");

    // at most one cell takes the broadcast entry
    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(load_vec))
        else $error("more than one cell loaded");

    // the located entry is a single occupied rank
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == foft_pkg::S_MOVE) |-> ($onehot(r_hit_oh) && (r_hit_oh & ~occ) == '0))
        else $error("bad located entry");

    // fill count never passes the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= foft_pkg::USED_W'(N))
        else $error("fill count overflow");
`endif

endmodule

/* dv/frequency_ordered_table_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frequency_ordered_table_checker: result predictor and scoreboard
// watches the request and result channels, keeps its own ranked table
// ----------------------------------------------------------------------------
module frequency_ordered_table_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    foft_in_if    i_req,
    foft_out_if   i_res,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic [foft_pkg::STATUS_W-1:0] status;
        logic [foft_pkg::POS_W-1:0]    position;
        logic [foft_pkg::KEY_W-1:0]    entry_key;
        logic [foft_pkg::OCOUNT_W-1:0] entry_count;
    } t_result;

    logic [foft_pkg::KEY_W-1:0]      key_tab [foft_pkg::ENTRIES];
    logic [foft_pkg::COUNT_BITS-1:0] cnt_tab [foft_pkg::ENTRIES];
    logic [foft_pkg::USED_W-1:0]     model_used;
    t_result                         expected_results [$];
    t_result                         want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        model_used   = '0;
    end

    // one request against the ranked table, returns the beat it must produce
    function automatic t_result apply_request(input logic [foft_pkg::OP_W-1:0]   op,
                                              input logic [foft_pkg::KEY_W-1:0]  k,
                                              input logic [foft_pkg::RANK_W-1:0] r);
        t_result                         res;
        int                              hit;
        int                              dest;
        logic [foft_pkg::COUNT_BITS-1:0] bumped;
        res           = '0;
        res.entry_key = k;
        if (op == foft_pkg::OP_APPEND) begin
            if (model_used >= foft_pkg::USED_W'(foft_pkg::ENTRIES)) begin
                res.status = foft_pkg::ST_FULL;
            end else begin
                key_tab[model_used[foft_pkg::IDX_W-1:0]] = k;
                cnt_tab[model_used[foft_pkg::IDX_W-1:0]] = '0;
                res.status   = foft_pkg::ST_OK;
                res.position = model_used[foft_pkg::POS_W-1:0];
                model_used   = model_used + 1'b1;
            end
        end else if (op == foft_pkg::OP_LOCATE) begin
            hit = -1;
            for (int i = 0; i < int'(model_used); i++) begin
                if (hit < 0 && key_tab[i] == k) hit = i;
            end
            if (hit < 0) begin
                res.status = foft_pkg::ST_NOT_FOUND;
            end else begin
                bumped = cnt_tab[hit];
                if (bumped != '1) bumped = bumped + 1'b1;
                // first earlier rank whose count no longer beats ours
                dest = hit;
                for (int j = hit - 1; j >= 0; j--) begin
                    if (cnt_tab[j] <= bumped) dest = j;
                end
                for (int m = hit; m > dest; m--) begin
                    key_tab[m] = key_tab[m-1];
                    cnt_tab[m] = cnt_tab[m-1];
                end
                key_tab[dest]   = k;
                cnt_tab[dest]   = bumped;
                res.status      = foft_pkg::ST_OK;
                res.position    = foft_pkg::POS_W'(dest);
                res.entry_count = foft_pkg::OCOUNT_W'(bumped);
            end
        end else begin
            res.position = r;
            if (foft_pkg::USED_W'(r) < model_used) begin
                res.status      = foft_pkg::ST_OK;
                res.entry_key   = key_tab[r];
                res.entry_count = foft_pkg::OCOUNT_W'(cnt_tab[r]);
            end else begin
                res.status    = foft_pkg::ST_NO_RANK;
                res.entry_key = '0;
            end
        end
        return res;
    endfunction

    function automatic bit field_ok(input string name, input logic [31:0] exp_val,
                                    input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_used = '0;
            expected_results.delete();
        end else begin
            // result side first: a beat accepted now belongs to an older request
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (!field_ok("status", 32'(want.status), 32'(i_res.status)))
                        o_fail_count++;
                    if (!field_ok("position", 32'(want.position), 32'(i_res.position)))
                        o_fail_count++;
                    if (!field_ok("entry_key", 32'(want.entry_key), 32'(i_res.entry_key)))
                        o_fail_count++;
                    if (!field_ok("entry_count", 32'(want.entry_count),
                                  32'(i_res.entry_count)))
                        o_fail_count++;
                end
            end
            if (i_req.valid && i_req.ready)
                expected_results.push_back(apply_request(i_req.operation, i_req.key,
                                                         i_req.rank));
        end
        o_pending = expected_results.size();
    end

endmodule

/* dv/frequency_ordered_table_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frequency_ordered_table_top_test: regression for the frequency ordered table
// directed corner beats, then random traffic with stalls
// ----------------------------------------------------------------------------
module frequency_ordered_table_top_test;

    // read decodes on the upper opcode bit, both codes are exercised
    localparam logic [foft_pkg::OP_W-1:0] OP_READ     = 2'd2;
    localparam logic [foft_pkg::OP_W-1:0] OP_READ_ALT = 2'd3;

    localparam int RANDOM_ITEMS    = 680;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 10;

    logic i_clk;
    logic i_rst_n;

    foft_in_if  req_ch ();
    foft_out_if res_ch ();

    int  fail_count;
    int  pending;
    int  sink_wait;
    int  quiet_cycles = 0;
    bit  idling        = 1'b0;
    bit  hold_off_req  = 1'b0;
    bit  hold_off_done = 1'b0;

    // keys reused so that locates mostly hit
    logic [foft_pkg::KEY_W-1:0] key_pool [8];

    frequency_ordered_table_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    frequency_ordered_table_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    // receiver: random back-pressure plus one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            sink_wait    <= 0;
        end else if (sink_wait > 0) begin
            res_ch.ready <= 1'b0;
            sink_wait    <= sink_wait - 1;
        end else if (hold_off_req && !hold_off_done) begin
            res_ch.ready  <= 1'b0;
            sink_wait     <= HOLD_OFF_CYCLES;
            hold_off_done <= 1'b1;
        end else if (idling && $urandom_range(0, 3) == 0) begin
            res_ch.ready <= 1'b0;
            sink_wait    <= idle_gap();
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // watchdog: no beat on either channel for too long ends the run
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one request beat and wait for it to be taken
    task automatic send_req(input logic [foft_pkg::OP_W-1:0]   op,
                            input logic [foft_pkg::KEY_W-1:0]  k,
                            input logic [foft_pkg::RANK_W-1:0] r);
        int gap;
        gap = (idling && $urandom_range(0, 2) == 0) ? idle_gap() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        // valid stays high across back-to-back beats
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.key       <= k;
        req_ch.rank      <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic random_request();
        int                         pick;
        logic [foft_pkg::OP_W-1:0]  op;
        logic [foft_pkg::KEY_W-1:0] k;
        pick = $urandom_range(0, 9);
        if (pick < 2)      op = foft_pkg::OP_APPEND;
        else if (pick < 7) op = foft_pkg::OP_LOCATE;
        else if (pick < 9) op = OP_READ;
        else               op = OP_READ_ALT;
        // a fifth of the keys span the full byte range, mostly misses
        if ($urandom_range(0, 4) == 0) k = foft_pkg::KEY_W'($urandom_range(0, 255));
        else                           k = key_pool[$urandom_range(0, 7)];
        send_req(op, k, foft_pkg::RANK_W'($urandom_range(0, 15)));
    endtask

    initial begin : stimulus
        req_ch.valid     <= 1'b0;
        req_ch.operation <= foft_pkg::OP_APPEND;
        req_ch.key       <= '0;
        req_ch.rank      <= '0;
        i_rst_n          <= 1'b0;
        foreach (key_pool[i]) key_pool[i] = foft_pkg::KEY_W'($urandom_range(0, 255));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, duplicates, equal-count moves, opcode alias
        idling = 1'b1;
        send_req(OP_READ,             8'h00, 4'd0);    // empty table, lowest rank
        send_req(OP_READ,             8'hFF, 4'd15);   // empty table, highest rank
        send_req(foft_pkg::OP_LOCATE, 8'h00, 4'd0);    // miss on empty table
        send_req(foft_pkg::OP_APPEND, 8'h00, 4'd0);
        send_req(foft_pkg::OP_APPEND, 8'hFF, 4'd15);
        send_req(foft_pkg::OP_APPEND, 8'hFF, 4'd0);    // duplicate key
        send_req(foft_pkg::OP_LOCATE, 8'hFF, 4'd0);    // first duplicate overtakes a zero count
        send_req(foft_pkg::OP_LOCATE, 8'hFF, 4'd0);    // already at the head
        send_req(foft_pkg::OP_LOCATE, 8'h00, 4'd0);
        send_req(OP_READ,             8'h00, 4'd2);    // untouched duplicate
        send_req(OP_READ,             8'h00, 4'd3);    // just past the tail
        send_req(OP_READ_ALT,         8'h00, 4'd0);
        send_req(OP_READ_ALT,         8'hA5, 4'd9);
        send_req(foft_pkg::OP_LOCATE, 8'h5A, 4'd7);    // miss on a populated table
        send_req(foft_pkg::OP_LOCATE, 8'h00, 4'd0);    // equal count ties move ahead
        send_req(OP_READ,             8'h00, 4'd0);
        send_req(OP_READ,             8'h00, 4'd1);

        // random traffic, every third window of 100 beats runs without gaps
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) idling = ((n / 100) % 3) != 2;
            if (n == 300) hold_off_req = 1'b1;
            random_request();
        end
        req_ch.valid <= 1'b0;

        // let the last accepted beat reach the checker, then drain
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* frequency_ordered_table_top.f */
rtl/foft_pkg.sv
rtl/foft_if.sv
rtl/foft_cell.sv
rtl/frequency_ordered_table_top.sv
dv/frequency_ordered_table_checker.sv
dv/frequency_ordered_table_top_test.sv
